// ===== hdl/tlr_pkg.sv =====
// Shared types and constants for the thick line tile rasterizer.
// Used by the channel interfaces, the line walker and the top level.
package tlr_pkg;

   // Default coordinate and width field sizes.
   localparam int COORD_BITS_DEF = 15;
   localparam int WIDTH_BITS_DEF = 4;

   // Width of the emitted tile coordinates.
   localparam int TILE_BITS = 16;

   // Request operation codes.
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   // One tile produced by the walker in the cycle of its request.
   typedef struct packed {
      logic                        emit;
      logic signed [TILE_BITS-1:0] tile_x;
      logic signed [TILE_BITS-1:0] tile_y;
      logic                        last;
   } tile_type;

endpackage

// ===== hdl/tlr_if.sv =====
// Valid/ready channel interfaces for the thick line tile rasterizer.
// Depends on tlr_pkg for default field sizes and the tile width.
interface tlr_req_if #(
   parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
   parameter int WIDTH_BITS = tlr_pkg::WIDTH_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic [WIDTH_BITS-1:0]        width;

   modport source (
      output valid, op, start_x, start_y, end_x, end_y, width,
      input  ready
   );
   modport sink (
      input  valid, op, start_x, start_y, end_x, end_y, width,
      output ready
   );
endinterface

interface tlr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tlr_pkg::TILE_BITS-1:0] tile_x;
   logic signed [tlr_pkg::TILE_BITS-1:0] tile_y;
   logic                                 last;

   modport source (
      output valid, tile_x, tile_y, last,
      input  ready
   );
   modport sink (
      input  valid, tile_x, tile_y, last,
      output ready
   );
endinterface

// ===== hdl/thick_line_tile_rasterizer_core.sv =====
// Top level of the thick line tile rasterizer: handshake and result register.
// Depends on tlr_pkg, tlr_req_if, tlr_rsp_if and tlr_walker.
//
//   channel   dir   handshake      payload
//   req       in    valid/ready    op, start_x, start_y, end_x, end_y, width
//   rsp       out   valid/ready    tile_x, tile_y, last
//
// One request per cycle unless stalled: a step request reads the run state,
// forms its tile and updates the state in the same cycle; the tile appears in
// the result register on the next cycle. A load request produces no tile.
// Synchronous reset clears the run (no line loaded) and the rsp valid flag.
// A stalled result blocks new requests only while it is still unread.
module thick_line_tile_rasterizer_core #(
   parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
   parameter int WIDTH_BITS = tlr_pkg::WIDTH_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   tlr_req_if.sink   req,
   tlr_rsp_if.source rsp
);

   logic              req_accept;
   logic              req_load;
   logic              req_step;
   tlr_pkg::tile_type walk_tile;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [tlr_pkg::TILE_BITS-1:0] rsp_tile_x_ff;
   logic signed [tlr_pkg::TILE_BITS-1:0] rsp_tile_y_ff;
   logic                                 rsp_last_ff;

   // Accept whenever the result register is free or being drained
   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;
   assign req_load   = req_accept && (tlr_pkg::op_type'(req.op) == tlr_pkg::OP_LOAD);
   assign req_step   = req_accept && (tlr_pkg::op_type'(req.op) == tlr_pkg::OP_STEP);

   tlr_walker #(
      .COORD_BITS (COORD_BITS),
      .WIDTH_BITS (WIDTH_BITS)
   ) u_walker (
      .clock   (clock),
      .reset   (reset),
      .load    (req_load),
      .step    (req_step),
      .start_x (req.start_x),
      .start_y (req.start_y),
      .end_x   (req.end_x),
      .end_y   (req.end_y),
      .width   (req.width),
      .tile    (walk_tile)
   );

   // Fill on a new tile, drop once taken
   always_comb begin
      if (walk_tile.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the tile payload
   always_ff @(posedge clock) begin
      if (walk_tile.emit) begin
         rsp_tile_x_ff <= walk_tile.tile_x;
         rsp_tile_y_ff <= walk_tile.tile_y;
         rsp_last_ff   <= walk_tile.last;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.tile_x = rsp_tile_x_ff;
   assign rsp.tile_y = rsp_tile_y_ff;
   assign rsp.last   = rsp_last_ff;

endmodule

// ===== hdl/tlr_walker.sv =====
// Line walker: Bresenham centre stepping plus square brush scan.
// Holds the run state and forms one tile per step request. Depends on tlr_pkg.
module tlr_walker #(
   parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
   parameter int WIDTH_BITS = tlr_pkg::WIDTH_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         step,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   input  logic [WIDTH_BITS-1:0]        width,
   output tlr_pkg::tile_type            tile
);

   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int ERR_BITS   = COORD_BITS + 3;
   localparam int HALF_BITS  = (WIDTH_BITS > 1) ? WIDTH_BITS - 1 : 1;
   localparam int CNT_BITS   = HALF_BITS + 1;
   localparam int SUM_BITS   = ((COORD_BITS > CNT_BITS) ? COORD_BITS : CNT_BITS) + 2;
   localparam int WIDE_BITS  = (SUM_BITS > tlr_pkg::TILE_BITS) ? SUM_BITS
                                                               : tlr_pkg::TILE_BITS;

   // Run state
   logic                         busy_ff, busy_in;
   logic signed [COORD_BITS-1:0] centre_x_ff, centre_x_in;
   logic signed [COORD_BITS-1:0] centre_y_ff, centre_y_in;
   logic signed [COORD_BITS-1:0] target_x_ff, target_x_in;
   logic signed [COORD_BITS-1:0] target_y_ff, target_y_in;
   logic [DELTA_BITS-1:0]        delta_x_ff, delta_x_in;
   logic [DELTA_BITS-1:0]        delta_y_ff, delta_y_in;
   logic                         dir_x_ff, dir_x_in;
   logic                         dir_y_ff, dir_y_in;
   logic signed [ERR_BITS-1:0]   error_ff, error_in;
   logic [HALF_BITS-1:0]         half_ff, half_in;
   logic [CNT_BITS-1:0]          col_ff, col_in;
   logic [CNT_BITS-1:0]          row_ff, row_in;

   // Load path
   logic signed [COORD_BITS:0]   diff_x, diff_y;
   logic [DELTA_BITS-1:0]        abs_x, abs_y;

   // Step path
   logic [CNT_BITS-1:0]          span;
   logic                         at_end, col_end, brush_done;
   logic [WIDE_BITS-1:0]         tile_x_wide, tile_y_wide;
   logic signed [ERR_BITS:0]     e2, dx_ext, dy_ext;
   logic                         move_x, move_y;
   logic [COORD_BITS-1:0]        inc_x, inc_y;

   // Absolute deltas of a new line
   always_comb begin
      diff_x = (COORD_BITS+1)'(end_x) - (COORD_BITS+1)'(start_x);
      diff_y = (COORD_BITS+1)'(end_y) - (COORD_BITS+1)'(start_y);
      abs_x  = diff_x[COORD_BITS] ? DELTA_BITS'(-diff_x) : DELTA_BITS'(diff_x);
      abs_y  = diff_y[COORD_BITS] ? DELTA_BITS'(-diff_y) : DELTA_BITS'(diff_y);
   end

   // Brush position and tile coordinates
   always_comb begin
      span        = {half_ff, 1'b0};
      at_end      = (centre_x_ff == target_x_ff) && (centre_y_ff == target_y_ff);
      col_end     = (col_ff >= span);
      brush_done  = col_end && (row_ff >= span);
      tile_x_wide = WIDE_BITS'(centre_x_ff) + WIDE_BITS'(col_ff) - WIDE_BITS'(half_ff);
      tile_y_wide = WIDE_BITS'(centre_y_ff) + WIDE_BITS'(row_ff) - WIDE_BITS'(half_ff);
      tile.emit   = step && busy_ff;
      tile.tile_x = tile_x_wide[tlr_pkg::TILE_BITS-1:0];
      tile.tile_y = tile_y_wide[tlr_pkg::TILE_BITS-1:0];
      tile.last   = at_end && brush_done;
   end

   // Bresenham decisions on the current error
   always_comb begin
      e2     = {error_ff, 1'b0};
      dx_ext = $signed((ERR_BITS+1)'(delta_x_ff));
      dy_ext = $signed((ERR_BITS+1)'(delta_y_ff));
      move_x = (e2 > -dy_ext);
      move_y = (e2 < dx_ext);
      inc_x  = dir_x_ff ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
      inc_y  = dir_y_ff ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
   end

   // Next run state
   always_comb begin
      busy_in     = busy_ff;
      centre_x_in = centre_x_ff;
      centre_y_in = centre_y_ff;
      target_x_in = target_x_ff;
      target_y_in = target_y_ff;
      delta_x_in  = delta_x_ff;
      delta_y_in  = delta_y_ff;
      dir_x_in    = dir_x_ff;
      dir_y_in    = dir_y_ff;
      error_in    = error_ff;
      half_in     = half_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (load) begin
         busy_in     = 1'b1;
         centre_x_in = start_x;
         centre_y_in = start_y;
         target_x_in = end_x;
         target_y_in = end_y;
         delta_x_in  = abs_x;
         delta_y_in  = abs_y;
         dir_x_in    = !(start_x < end_x);
         dir_y_in    = !(start_y < end_y);
         error_in    = $signed(ERR_BITS'(abs_x) - ERR_BITS'(abs_y));
         half_in     = HALF_BITS'(width >> 1);
         col_in      = '0;
         row_in      = '0;
      end else if (step && busy_ff) begin
         if (!brush_done) begin
            // advance through the brush, columns inner
            if (col_end) begin
               col_in = '0;
               row_in = row_ff + CNT_BITS'(1);
            end else begin
               col_in = col_ff + CNT_BITS'(1);
            end
         end else begin
            col_in = '0;
            row_in = '0;
            if (at_end) begin
               busy_in = 1'b0;
            end else begin
               // advance the centre one Bresenham step
               error_in = error_ff
                        - (move_x ? $signed(ERR_BITS'(delta_y_ff)) : '0)
                        + (move_y ? $signed(ERR_BITS'(delta_x_ff)) : '0);
               if (move_x) begin
                  centre_x_in = centre_x_ff + inc_x;
               end
               if (move_y) begin
                  centre_y_in = centre_y_ff + inc_y;
               end
            end
         end
      end
   end

   // Hold run control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Hold run data
   always_ff @(posedge clock) begin
      centre_x_ff <= centre_x_in;
      centre_y_ff <= centre_y_in;
      target_x_ff <= target_x_in;
      target_y_ff <= target_y_in;
      delta_x_ff  <= delta_x_in;
      delta_y_ff  <= delta_y_in;
      dir_x_ff    <= dir_x_in;
      dir_y_ff    <= dir_y_in;
      error_ff    <= error_in;
      half_ff     <= half_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
   end

endmodule
